### design/rlp_pkg.sv
`default_nettype none

package rlp_pkg;

    // Default accumulator widths for the two decimal fields
    localparam int REQ_VALUE_BITS_DEF   = 8;
    localparam int PARAM_VALUE_BITS_DEF = 16;

    localparam int BYTE_W        = 8;
    localparam int STATUS_W      = 2;
    localparam int REQ_VALUE_W   = 8;
    localparam int PARAM_VALUE_W = 16;
    localparam int RESULT_DATA_W = 2 * BYTE_W + REQ_VALUE_W + PARAM_VALUE_W;

    typedef enum logic [STATUS_W-1:0] {
        STATUS_MORE  = 2'd0,
        STATUS_DONE  = 2'd1,
        STATUS_ERROR = 2'd2
    } status_t;

    // ASCII codes
    localparam logic [BYTE_W-1:0] CH_LF    = 8'h0a;
    localparam logic [BYTE_W-1:0] CH_CR    = 8'h0d;
    localparam logic [BYTE_W-1:0] CH_SPACE = 8'h20;
    localparam logic [BYTE_W-1:0] CH_ZERO  = 8'h30;
    localparam logic [BYTE_W-1:0] CH_NINE  = 8'h39;
    localparam logic [BYTE_W-1:0] CH_A     = 8'h41;
    localparam logic [BYTE_W-1:0] CH_B     = 8'h42;
    localparam logic [BYTE_W-1:0] CH_E     = 8'h45;
    localparam logic [BYTE_W-1:0] CH_F     = 8'h46;
    localparam logic [BYTE_W-1:0] CH_H     = 8'h48;
    localparam logic [BYTE_W-1:0] CH_K     = 8'h4b;
    localparam logic [BYTE_W-1:0] CH_L     = 8'h4c;
    localparam logic [BYTE_W-1:0] CH_M     = 8'h4d;
    localparam logic [BYTE_W-1:0] CH_P     = 8'h50;
    localparam logic [BYTE_W-1:0] CH_Q     = 8'h51;
    localparam logic [BYTE_W-1:0] CH_R     = 8'h52;
    localparam logic [BYTE_W-1:0] CH_S     = 8'h53;
    localparam logic [BYTE_W-1:0] CH_T     = 8'h54;
    localparam logic [BYTE_W-1:0] CH_U     = 8'h55;
    localparam logic [BYTE_W-1:0] CH_W     = 8'h57;
    localparam logic [BYTE_W-1:0] CH_X     = 8'h58;
    localparam logic [BYTE_W-1:0] CH_F_LC  = 8'h66;
    localparam logic [BYTE_W-1:0] CH_NONE  = 8'h00;

    typedef struct packed {
        status_t                    status;
        logic [BYTE_W-1:0]          request_code;
        logic [REQ_VALUE_W-1:0]     request_value;
        logic [BYTE_W-1:0]          param_code;
        logic [PARAM_VALUE_W-1:0]   param_value;
    } result_t;

    function automatic logic is_digit(input logic [BYTE_W-1:0] c);
        return (c >= CH_ZERO) && (c <= CH_NINE);
    endfunction

    function automatic logic is_newline(input logic [BYTE_W-1:0] c);
        return (c == CH_LF) || (c == CH_CR);
    endfunction

    function automatic logic is_request_letter(input logic [BYTE_W-1:0] c);
        return (c == CH_Q) || (c == CH_T) || (c == CH_L) || (c == CH_M) ||
               (c == CH_U) || (c == CH_X) || (c == CH_P) || (c == CH_S) ||
               (c == CH_B) || (c == CH_E) || (c == CH_W) || (c == CH_K) ||
               (c == CH_F) || (c == CH_F_LC) || (c == CH_H);
    endfunction

    function automatic logic is_param_letter(input logic [BYTE_W-1:0] c);
        return (c == CH_P) || (c == CH_E) || (c == CH_F) ||
               (c == CH_A) || (c == CH_R) || (c == CH_B);
    endfunction

endpackage

`default_nettype wire

### design/rlp_parser.sv
`default_nettype none

module rlp_parser #(
    parameter int REQ_VALUE_BITS   = rlp_pkg::REQ_VALUE_BITS_DEF,
    parameter int PARAM_VALUE_BITS = rlp_pkg::PARAM_VALUE_BITS_DEF
) (
    input  wire logic                        aclk,
    input  wire logic                        aresetn,
    input  wire logic                        step,
    input  wire logic [rlp_pkg::BYTE_W-1:0]  rx_byte,
    output rlp_pkg::result_t                 result
);

    typedef enum logic [2:0] {
        ST_REQ_CODE    = 3'd0,
        ST_REQ_VALUE   = 3'd1,
        ST_PARAM_CODE  = 3'd2,
        ST_PARAM_VALUE = 3'd3,
        ST_ERROR       = 3'd4
    } state_t;

    state_t                            state_reg,       state_next;
    logic [rlp_pkg::BYTE_W-1:0]        req_code_reg,    req_code_next;
    logic [REQ_VALUE_BITS-1:0]         req_value_reg,   req_value_next;
    logic [rlp_pkg::BYTE_W-1:0]        param_code_reg,  param_code_next;
    logic [PARAM_VALUE_BITS-1:0]       param_value_reg, param_value_next;
    rlp_pkg::status_t                  status;

    logic [REQ_VALUE_BITS-1:0]         req_acc;
    logic [PARAM_VALUE_BITS-1:0]       param_acc;

    // value * 10 + digit, wrapping at the accumulator width
    assign req_acc = (req_value_reg << 3) + (req_value_reg << 1)
                   + REQ_VALUE_BITS'(rx_byte[3:0]);
    assign param_acc = (param_value_reg << 3) + (param_value_reg << 1)
                     + PARAM_VALUE_BITS'(rx_byte[3:0]);

    always_comb begin
        state_next       = state_reg;
        req_code_next    = req_code_reg;
        req_value_next   = req_value_reg;
        param_code_next  = param_code_reg;
        param_value_next = param_value_reg;
        status           = rlp_pkg::STATUS_MORE;
        unique case (state_reg)
            ST_REQ_CODE: begin
                if (rlp_pkg::is_request_letter(rx_byte)) begin
                    req_code_next  = rx_byte;
                    req_value_next = '0;
                    state_next     = ST_REQ_VALUE;
                end else if (!rlp_pkg::is_newline(rx_byte)) begin
                    state_next = ST_ERROR;
                    status     = rlp_pkg::STATUS_ERROR;
                end
            end
            ST_REQ_VALUE: begin
                if (rlp_pkg::is_digit(rx_byte)) begin
                    req_value_next = req_acc;
                end else if (rx_byte == rlp_pkg::CH_SPACE) begin
                    state_next = ST_PARAM_CODE;
                end else begin
                    state_next = ST_ERROR;
                    status     = rlp_pkg::STATUS_ERROR;
                end
            end
            ST_PARAM_CODE: begin
                if (rlp_pkg::is_param_letter(rx_byte)) begin
                    param_code_next  = rx_byte;
                    param_value_next = '0;
                    state_next       = ST_PARAM_VALUE;
                end else begin
                    param_code_next = rlp_pkg::CH_NONE;
                    state_next      = ST_ERROR;
                    status          = rlp_pkg::STATUS_ERROR;
                end
            end
            ST_PARAM_VALUE: begin
                if (rlp_pkg::is_digit(rx_byte)) begin
                    param_value_next = param_acc;
                end else if (rlp_pkg::is_newline(rx_byte)) begin
                    state_next = ST_REQ_CODE;
                    status     = rlp_pkg::STATUS_DONE;
                end else begin
                    param_code_next = rlp_pkg::CH_NONE;
                    state_next      = ST_ERROR;
                    status          = rlp_pkg::STATUS_ERROR;
                end
            end
            default: begin
                // error state and unused codes: wait for a newline
                if (rlp_pkg::is_newline(rx_byte)) begin
                    state_next = ST_REQ_CODE;
                    status     = rlp_pkg::STATUS_DONE;
                end else begin
                    param_code_next = rlp_pkg::CH_NONE;
                    state_next      = ST_ERROR;
                    status          = rlp_pkg::STATUS_ERROR;
                end
            end
        endcase
    end

    always_comb begin
        result.status        = status;
        result.request_code  = req_code_next;
        result.request_value = rlp_pkg::REQ_VALUE_W'(req_value_next);
        result.param_code    = param_code_next;
        result.param_value   = rlp_pkg::PARAM_VALUE_W'(param_value_next);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg       <= ST_REQ_CODE;
            req_code_reg    <= '0;
            req_value_reg   <= '0;
            param_code_reg  <= rlp_pkg::CH_NONE;
            param_value_reg <= '0;
        end else if (step) begin
            state_reg       <= state_next;
            req_code_reg    <= req_code_next;
            req_value_reg   <= req_value_next;
            param_code_reg  <= param_code_next;
            param_value_reg <= param_value_next;
        end
    end

endmodule

`default_nettype wire

### design/response_line_parser.sv
// Response line parser.
//
// Input channel (s_axis_*): one received ASCII byte per request. The parser
// reads lines of the form: request letter, decimal digits, space, parameter
// letter, decimal digits, newline (CR or LF). CR/LF ahead of a line is skipped.
// Result channel (m_axis_*): exactly one result request per input byte,
// carrying the status (need more, completed, error) in tuser and the current
// request code/value and parameter code/value in tdata.
// Path: a byte accepted on s_axis_* passes through the input register, then the
// result register, before it shows on m_axis_*. Throughput: one byte per cycle
// while m_axis_tready is high, set by the state update between the two registers.
// Stalls: while m_axis_tready is low the result holds; one more byte is held
// in the input register, after which s_axis_tready drops until the result is
// taken.
// Reset (aresetn low, synchronous): both registers empty, parser back to the
// request code state with all codes and values cleared.
// After an error the parser drops bytes (reporting error) until a newline,
// which reports completed.

`default_nettype none

module response_line_parser #(
    parameter int REQ_VALUE_BITS   = rlp_pkg::REQ_VALUE_BITS_DEF,
    parameter int PARAM_VALUE_BITS = rlp_pkg::PARAM_VALUE_BITS_DEF
) (
    input  wire logic                               aclk,
    input  wire logic                               aresetn,
    // tdata: [7:0] rx_byte
    input  wire logic                               s_axis_tvalid,
    output logic                                    s_axis_tready,
    input  wire logic [rlp_pkg::BYTE_W-1:0]         s_axis_tdata,
    // tdata: [7:0] request_code, [15:8] request_value, [23:16] param_code,
    //        [39:24] param_value
    output logic                                    m_axis_tvalid,
    input  wire logic                               m_axis_tready,
    output logic [rlp_pkg::RESULT_DATA_W-1:0]       m_axis_tdata,
    // tuser: [1:0] status
    output logic [rlp_pkg::STATUS_W-1:0]            m_axis_tuser
);

    logic                          in_valid_reg;
    logic [rlp_pkg::BYTE_W-1:0]    in_byte_reg;
    logic                          out_valid_reg;
    rlp_pkg::result_t              out_result_reg;
    rlp_pkg::result_t              parse_result;
    logic                          advance;

    // Advance the held byte through the parser when the result slot is free or being taken
    assign advance       = in_valid_reg && (!out_valid_reg || m_axis_tready);
    assign s_axis_tready = !in_valid_reg || advance;

    rlp_parser #(
        .REQ_VALUE_BITS   (REQ_VALUE_BITS),
        .PARAM_VALUE_BITS (PARAM_VALUE_BITS)
    ) u_parser (
        .aclk    (aclk),
        .aresetn (aresetn),
        .step    (advance),
        .rx_byte (in_byte_reg),
        .result  (parse_result)
    );

    // Input register: hold one byte until the parser takes it
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_axis_tready) begin
            in_valid_reg <= s_axis_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_axis_tvalid && s_axis_tready) begin
            in_byte_reg <= s_axis_tdata;
        end
    end

    // Result register: load on advance, drop once the receiver takes it
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (advance) begin
            out_valid_reg <= 1'b1;
        end else if (m_axis_tready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            out_result_reg <= parse_result;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tuser  = out_result_reg.status;
    assign m_axis_tdata  = {out_result_reg.param_value, out_result_reg.param_code,
                            out_result_reg.request_value, out_result_reg.request_code};

endmodule

`default_nettype wire

### design/rlp_checker.sv
`default_nettype none

module rlp_checker (
    input wire logic                               aclk,
    input wire logic                               aresetn,
    input wire logic                               s_axis_tvalid,
    input wire logic                               s_axis_tready,
    input wire logic [rlp_pkg::BYTE_W-1:0]         s_axis_tdata,
    input wire logic                               m_axis_tvalid,
    input wire logic                               m_axis_tready,
    input wire logic [rlp_pkg::RESULT_DATA_W-1:0]  m_axis_tdata,
    input wire logic [rlp_pkg::STATUS_W-1:0]       m_axis_tuser
);

    logic [rlp_pkg::BYTE_W-1:0] pc;

    assign pc = m_axis_tdata[3*rlp_pkg::BYTE_W-1:2*rlp_pkg::BYTE_W];

    // Result channel is empty in the cycle after reset is asserted
    a_reset_empty: assert property (@(posedge aclk)
        !aresetn |=> !m_axis_tvalid)
        else $error("result valid after reset");

    // A stalled input request holds until it is taken
    a_in_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        s_axis_tvalid && !s_axis_tready |=>
            s_axis_tvalid && $stable(s_axis_tdata))
        else $error("stalled input changed");

    // A stalled result request holds
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_axis_tvalid && !m_axis_tready |=>
            m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))
        else $error("stalled result changed");

    // Status is one of the three defined codes
    a_status: assert property (@(posedge aclk) disable iff (!aresetn)
        m_axis_tvalid |-> (m_axis_tuser == rlp_pkg::STATUS_MORE) ||
                          (m_axis_tuser == rlp_pkg::STATUS_DONE) ||
                          (m_axis_tuser == rlp_pkg::STATUS_ERROR))
        else $error("undefined status code");

    // Parameter code is unknown or one of the parameter letters
    a_param_code: assert property (@(posedge aclk) disable iff (!aresetn)
        m_axis_tvalid |-> (pc == rlp_pkg::CH_NONE) || (pc == rlp_pkg::CH_P) ||
                          (pc == rlp_pkg::CH_E) || (pc == rlp_pkg::CH_F) ||
                          (pc == rlp_pkg::CH_A) || (pc == rlp_pkg::CH_R) ||
                          (pc == rlp_pkg::CH_B))
        else $error("bad parameter code");

endmodule

bind response_line_parser rlp_checker u_rlp_checker (
    .aclk          (aclk),
    .aresetn       (aresetn),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
);

`default_nettype wire
